// ----- rtl/core/pnorm_pkg.sv -----
// ============================================================================
// pnorm_pkg: shared types and constants for the PCM peak normalizer
// Sample and product widths, request codes, and the sequencer state type.
// ============================================================================
package pnorm_pkg;

   // Sample width and the fixed width of the target register
   localparam int SAMPLE_WIDTH = 16;
   localparam int TARGET_WIDTH = 16;

   // Product |sample| * target, numerator 2*m*t + p, quotient and header part
   localparam int PROD_WIDTH  = SAMPLE_WIDTH + TARGET_WIDTH;
   localparam int NUM_WIDTH   = PROD_WIDTH + 2;
   localparam int QUOT_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int HEAD_WIDTH  = NUM_WIDTH - QUOT_WIDTH;
   localparam int CMP_WIDTH   = (HEAD_WIDTH > QUOT_WIDTH + 1) ? HEAD_WIDTH : QUOT_WIDTH + 1;
   localparam int CNT_WIDTH   = $clog2(QUOT_WIDTH);

   localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = 16'd32767;

   // Request codes
   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_MEASURE = 2'd1,
      REQ_APPLY   = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

endpackage

// ----- rtl/core/pnorm_req_if.sv -----
// ============================================================================
// pnorm_req_if: request channel of the PCM peak normalizer
// Valid/ready handshake carrying a request code and one PCM sample.
// ============================================================================
interface pnorm_req_if import pnorm_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic [1:0]                     req_type;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output req_type, output sample, input ready);
   modport sink   (input valid, input req_type, input sample, output ready);
endinterface

// ----- rtl/core/pnorm_rsp_if.sv -----
// ============================================================================
// pnorm_rsp_if: response channel of the PCM peak normalizer
// Valid/ready handshake carrying one scaled sample and its status flags.
// ============================================================================
interface pnorm_rsp_if import pnorm_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] scaled_sample;
   logic                           clipped;
   logic                           no_peak;

   modport source (output valid, output scaled_sample, output clipped, output no_peak,
                   input ready);
   modport sink   (input valid, input scaled_sample, input clipped, input no_peak,
                   output ready);
endinterface

// ----- rtl/core/pcm_peak_normalizer_core.sv -----
// ============================================================================
// pcm_peak_normalizer_core: two-pass peak normalizer for signed PCM samples
// Clear and measure words track the peak magnitude; apply words return
// round(sample * target / peak) through a bit-serial restoring divider.
// ============================================================================
//
//   channel   dir   handshake      payload
//   -------   ---   ------------   -------------------------------------
//   req_chan  in    valid/ready    req_type[1:0], sample[15:0]
//   rsp_chan  out   valid/ready    scaled_sample[15:0], clipped, no_peak
//   csr       in    csr_wr_en      csr_wr_data[15:0] (target_peak)
//
// Clear, measure and unused words finish when accepted. An apply word runs
// accept, a multiply state, a setup state, 17 divider steps (one quotient bit
// per cycle) and a finish state that loads the output register; setup goes to
// finish at once on overflow, and a zero peak goes from accept to finish. One
// word is in work at a time; the response register holds its word while the
// next one runs and only a stalled response holds the sequencer in its last state.
// Reset (synchronous) clears the peak, sets target_peak to 32767 and drops
// the response valid.
module pcm_peak_normalizer_core import pnorm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   pnorm_req_if.sink               req_chan,
   pnorm_rsp_if.source             rsp_chan,
   input  logic                    csr_wr_en,
   input  logic [TARGET_WIDTH-1:0] csr_wr_data
);

   state_type                  state_ff, state_in;
   logic [TARGET_WIDTH-1:0]    target_ff, target_in;
   logic [SAMPLE_WIDTH-1:0]    peak_ff, peak_in;
   logic [SAMPLE_WIDTH-1:0]    mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic                       zero_ff, zero_in;
   logic                       ovf_ff, ovf_in;
   logic [PROD_WIDTH-1:0]      prod_ff, prod_in;
   logic [QUOT_WIDTH-1:0]      num_ff, num_in;
   logic [QUOT_WIDTH:0]        rem_ff, rem_in;
   logic [QUOT_WIDTH-1:0]      quot_ff, quot_in;
   logic [CNT_WIDTH-1:0]       cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic                       rsp_clip_ff, rsp_clip_in;
   logic                       rsp_nopk_ff, rsp_nopk_in;

   logic                       req_fire;
   logic [SAMPLE_WIDTH-1:0]    smp_mag;
   logic [QUOT_WIDTH-1:0]      divisor;
   logic [NUM_WIDTH-1:0]       numer;
   logic [CMP_WIDTH-1:0]       head_ext;
   logic [QUOT_WIDTH:0]        rem_sh;
   logic                       rem_ge;
   logic                       out_load;
   logic [QUOT_WIDTH-1:0]      half_q;
   logic [QUOT_WIDTH-1:0]      sat_mag;
   logic                       sat_clip;

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Magnitude of the incoming sample; the most negative value maps to 2^(W-1)
   assign smp_mag = req_chan.sample[SAMPLE_WIDTH-1] ? (~req_chan.sample + 1'b1)
                                                     : req_chan.sample;

   // Divisor 2*peak, numerator 2*m*t + peak
   assign divisor  = {peak_ff, 1'b0};
   assign numer    = NUM_WIDTH'({prod_ff, 1'b0}) + NUM_WIDTH'(peak_ff);
   assign head_ext = CMP_WIDTH'(numer[NUM_WIDTH-1:QUOT_WIDTH]);

   // One restoring step: shift in a numerator bit, subtract when it fits
   assign rem_sh = {rem_ff[QUOT_WIDTH-1:0], num_ff[QUOT_WIDTH-1]};
   assign rem_ge = (rem_sh >= {1'b0, divisor});

   // Saturate the quotient magnitude against the signed range
   assign half_q = QUOT_WIDTH'(1) << (SAMPLE_WIDTH - 1);
   always_comb begin
      if (neg_ff) begin
         sat_clip = ovf_ff || (quot_ff > half_q);
         sat_mag  = sat_clip ? half_q : quot_ff;
      end else begin
         sat_clip = ovf_ff || (quot_ff >= half_q);
         sat_mag  = sat_clip ? (half_q - 1'b1) : quot_ff;
      end
   end

   assign out_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);

   // Sequencer and datapath next state
   always_comb begin
      state_in  = state_ff;
      target_in = csr_wr_en ? csr_wr_data : target_ff;
      peak_in   = peak_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      ovf_in    = ovf_ff;
      prod_in   = prod_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      cnt_in    = cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.req_type)
                  REQ_CLEAR: begin
                     peak_in = '0;
                  end
                  REQ_MEASURE: begin
                     if (smp_mag > peak_ff) begin
                        peak_in = smp_mag;
                     end
                  end
                  REQ_APPLY: begin
                     mag_in  = smp_mag;
                     neg_in  = req_chan.sample[SAMPLE_WIDTH-1];
                     zero_in = (peak_ff == '0);
                     ovf_in  = 1'b0;
                     state_in = (peak_ff == '0) ? ST_FIN : ST_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = PROD_WIDTH'(mag_ff) * PROD_WIDTH'(target_ff);
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            // Quotient does not fit in QUOT_WIDTH bits: saturate at once
            ovf_in  = (head_ext >= CMP_WIDTH'(divisor));
            rem_in  = head_ext[QUOT_WIDTH:0];
            num_in  = numer[QUOT_WIDTH-1:0];
            quot_in = '0;
            cnt_in  = '0;
            state_in = (head_ext >= CMP_WIDTH'(divisor)) ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
            quot_in = {quot_ff[QUOT_WIDTH-2:0], rem_ge};
            num_in  = {num_ff[QUOT_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(QUOT_WIDTH - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: load a finished word, drop valid once taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;
      rsp_nopk_in  = rsp_nopk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (zero_ff) begin
            rsp_data_in = '0;
            rsp_clip_in = 1'b0;
            rsp_nopk_in = 1'b1;
         end else begin
            rsp_data_in = neg_ff ? SAMPLE_WIDTH'(~sat_mag + 1'b1) : SAMPLE_WIDTH'(sat_mag);
            rsp_clip_in = sat_clip;
            rsp_nopk_in = 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= TARGET_RESET;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      ovf_ff      <= ovf_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
      rsp_nopk_ff <= rsp_nopk_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.scaled_sample = rsp_data_ff;
   assign rsp_chan.clipped       = rsp_clip_ff;
   assign rsp_chan.no_peak       = rsp_nopk_ff;

`ifndef NO_ASSERTIONS
   // A response appears only when the sequencer finishes a word
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finish state");

   // The peak moves only on an accepted word
   a_peak_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(peak_ff))
      else $error("peak changed without an accepted word");

   // The divider never runs past its last quotient bit
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_WIDTH'(QUOT_WIDTH - 1)))
      else $error("divider step count out of range");

   // A zero-peak response carries a zero sample and no clip
   a_no_peak_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nopk_ff) |-> (rsp_data_ff == '0 && !rsp_clip_ff))
      else $error("zero-peak response with nonzero payload");
`endif

endmodule
